>>> hdl/bvrq_pkg.sv
// Package for the bit vector range query block: item and config types,
// command, order and register codes, byte mapping helpers. No dependencies.
package bvrq_pkg;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_INVERT = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  localparam logic [1:0] MODE_INDEP  = 2'd0;
  localparam logic [1:0] MODE_LITTLE = 2'd1;
  localparam logic [1:0] MODE_BIG    = 2'd2;
  localparam logic [1:0] MODE_REVBIG = 2'd3;

  localparam logic REG_LENGTH = 1'b0;
  localparam logic REG_ORDER  = 1'b1;

  localparam logic [6:0] LENGTH_RESET = 7'd64;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] byte_addr;
    logic [7:0] byte_data;
    logic [8:0] range_first;
    logic [8:0] range_last;
    logic       last_is_end;
    logic       match_value;
    logic       relative;
  } in_t;

  typedef struct packed {
    logic       range_ok;
    logic       all_set;
    logic       any_set;
    logic       none_set;
    logic [9:0] ones_count;
    logic       first_found;
    logic [8:0] first_pos;
    logic       last_found;
    logic [8:0] last_pos;
  } out_t;

  typedef struct packed {
    logic [6:0] nbytes;
    logic [1:0] mode;
  } cfg_t;

  function automatic logic lsb_first(input logic [1:0] mode);
    return (mode == MODE_LITTLE) || (mode == MODE_BIG);
  endfunction

  // byte holding bit group grp; the big modes (BIG, REVBIG) count from the top byte
  function automatic logic [6:0] byte_of(input logic [6:0] grp, input logic [6:0] nbytes,
                                         input logic [1:0] mode);
    logic [6:0] b;
    if ((mode == MODE_BIG) || (mode == MODE_REVBIG)) begin
      b = nbytes - 7'd1 - grp;
    end else begin
      b = grp;
    end
    return b;
  endfunction

endpackage

>>> hdl/bvrq_if.sv
// Valid/ready channel interfaces for command and result words.
// Depends on bvrq_pkg.
interface bvrq_in_if;
  import bvrq_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bvrq_out_if;
  import bvrq_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/bvrq_mem.sv
// Byte store: one write port, one read port, registered read data.
// No dependencies.
module bvrq_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hdl/bvrq_ctrl.sv
// Command sequencer: byte writes, bit read-modify-write and the byte-wise
// range scan with count and first/last search. Depends on bvrq_pkg, bvrq_mem.
module bvrq_ctrl #(
  parameter int AW = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bvrq_pkg::cfg_t cfg_i,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  bvrq_pkg::in_t  req_i,
  output logic           res_valid_o,
  input  logic           res_take_i,
  output bvrq_pkg::out_t res_o,
  output logic           we_o,
  output logic [AW-1:0]  waddr_o,
  output logic [7:0]     wdata_o,
  output logic [AW-1:0]  raddr_o,
  input  logic [7:0]     rdata_i
);
  import bvrq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_RMW    = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_LASTP  = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_q, state_d;
  in_t        cur_q;
  logic       ok_q, ok_d;
  logic [6:0] grp_q, grp_d;
  logic [6:0] pg_q;
  logic       pv_q;
  logic [9:0] ones_q, ones_d;
  logic       ffound_q, ffound_d, lfound_q, lfound_d;
  logic [9:0] fpos_q, fpos_d, lpos_q, lpos_d;

  logic [9:0] nbits, first10, last_eff, span;
  logic       range_valid, lsb;
  logic [6:0] gfirst, glast, bit_byte, scan_byte;
  logic [2:0] sub, lo, hi, low_j, high_j;
  logic [7:0] bmask, bits, inmask, match;
  logic [3:0] cnt;
  logic [9:0] fpos_rel, lpos_rel;

  always_comb begin
    nbits       = {cfg_i.nbytes, 3'b000};
    first10     = {1'b0, cur_q.range_first};
    last_eff    = cur_q.last_is_end ? (nbits - 10'd1) : {1'b0, cur_q.range_last};
    range_valid = (cfg_i.nbytes != 7'd0) && (first10 <= last_eff) && (last_eff < nbits);
    span        = last_eff - first10 + 10'd1;
    lsb         = lsb_first(cfg_i.mode);
    gfirst      = {1'b0, cur_q.range_first[8:3]};
    glast       = last_eff[9:3];
    sub         = cur_q.range_first[2:0];
    bit_byte    = byte_of(gfirst, cfg_i.nbytes, cfg_i.mode);
    scan_byte   = byte_of(grp_q, cfg_i.nbytes, cfg_i.mode);
    bmask       = lsb ? (8'h01 << sub) : (8'h80 >> sub);
  end

  // one fetched byte in index order, clipped to the range
  always_comb begin
    lo = (pg_q == gfirst) ? cur_q.range_first[2:0] : 3'd0;
    hi = (pg_q == glast) ? last_eff[2:0] : 3'd7;
    cnt = 4'd0;
    low_j = 3'd0;
    high_j = 3'd0;
    for (int j = 0; j < 8; j++) begin
      bits[j]   = lsb ? rdata_i[j] : rdata_i[7-j];
      inmask[j] = (3'(j) >= lo) && (3'(j) <= hi);
    end
    match = ~(bits ^ {8{cur_q.match_value}}) & inmask;
    for (int j = 0; j < 8; j++) begin
      cnt = cnt + 4'(bits[j] & inmask[j]);
    end
    for (int j = 7; j >= 0; j--) begin
      if (match[j]) begin
        low_j = 3'(j);
      end
    end
    for (int j = 0; j < 8; j++) begin
      if (match[j]) begin
        high_j = 3'(j);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    ok_d     = ok_q;
    grp_d    = grp_q;
    ones_d   = ones_q;
    ffound_d = ffound_q;
    fpos_d   = fpos_q;
    lfound_d = lfound_q;
    lpos_d   = lpos_q;
    we_o     = 1'b0;
    waddr_o  = AW'(bit_byte);
    wdata_o  = rdata_i;
    raddr_o  = AW'(bit_byte);

    if (pv_q) begin
      ones_d = ones_q + 10'(cnt);
      if (|match) begin
        lfound_d = 1'b1;
        lpos_d   = {pg_q, high_j};
        if (!ffound_q) begin
          ffound_d = 1'b1;
          fpos_d   = {pg_q, low_j};
        end
      end
    end

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        ok_d     = 1'b0;
        ones_d   = 10'd0;
        ffound_d = 1'b0;
        fpos_d   = 10'd0;
        lfound_d = 1'b0;
        lpos_d   = 10'd0;
        state_d  = S_OUT;
        case (cur_q.cmd)
          CMD_WRITE: begin
            waddr_o = AW'({1'b0, cur_q.byte_addr});
            wdata_o = cur_q.byte_data;
            we_o    = ({1'b0, cur_q.byte_addr} < cfg_i.nbytes);
          end
          CMD_SET, CMD_INVERT: begin
            if (first10 < nbits) begin
              state_d = S_RMW;
            end
          end
          default: begin
            if (range_valid) begin
              ok_d    = 1'b1;
              grp_d   = gfirst;
              state_d = S_SCAN;
            end
          end
        endcase
      end
      S_RMW: begin
        we_o = 1'b1;
        if (cur_q.cmd == CMD_INVERT) begin
          wdata_o = rdata_i ^ bmask;
        end else if (cur_q.match_value) begin
          wdata_o = rdata_i | bmask;
        end else begin
          wdata_o = rdata_i & ~bmask;
        end
        state_d = S_OUT;
      end
      S_SCAN: begin
        raddr_o = AW'(scan_byte);
        if (grp_q == glast) begin
          state_d = S_LASTP;
        end else begin
          grp_d = grp_q + 7'd1;
        end
      end
      S_LASTP: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    fpos_rel = cur_q.relative ? (fpos_q - first10) : fpos_q;
    lpos_rel = cur_q.relative ? (lpos_q - first10) : lpos_q;
    res_o.range_ok    = ok_q;
    res_o.all_set     = ok_q && (ones_q == span);
    res_o.any_set     = ok_q && (ones_q != 10'd0);
    res_o.none_set    = ok_q && (ones_q == 10'd0);
    res_o.ones_count  = ok_q ? ones_q : 10'd0;
    res_o.first_found = ok_q && ffound_q;
    res_o.first_pos   = (ok_q && ffound_q) ? fpos_rel[8:0] : 9'd0;
    res_o.last_found  = ok_q && lfound_q;
    res_o.last_pos    = (ok_q && lfound_q) ? lpos_rel[8:0] : 9'd0;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ok_q    <= 1'b0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ok_q    <= ok_d;
      pv_q    <= (state_q == S_SCAN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      cur_q <= req_i;
    end
    grp_q    <= grp_d;
    pg_q     <= grp_q;
    ones_q   <= ones_d;
    ffound_q <= ffound_d;
    fpos_q   <= fpos_d;
    lfound_q <= lfound_d;
    lpos_q   <= lpos_d;
  end

endmodule

>>> hdl/bit_vector_range_query.sv
// A byte write is done in decode, a set/invert bit adds a read-modify-write state, and
// a range query over G bytes scans them from accept to result word; the scan reads one store byte per cycle.
// A new command word is taken once the previous one is handed to the output register.
// Reset: length 64 bytes, order mode 0; store contents undefined until written.
module bit_vector_range_query #(
  parameter int STORE_BYTES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [6:0]          cfg_wdata_i,
  bvrq_in_if.sink             req,
  bvrq_out_if.source          rsp
);
  import bvrq_pkg::*;

  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  logic [6:0]    len_q;
  logic [1:0]    mode_q;
  cfg_t          cfg;
  logic          res_valid, res_take;
  out_t          res;
  logic          out_valid_q;
  out_t          out_data_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LENGTH_RESET;
      mode_q <= MODE_INDEP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LENGTH: len_q  <= cfg_wdata_i;
        REG_ORDER:  mode_q <= cfg_wdata_i[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.nbytes = (int'(len_q) > STORE_BYTES) ? 7'(STORE_BYTES) : len_q;
    cfg.mode   = mode_q;
  end

  assign res_take = res_valid && (!out_valid_q || rsp.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res;
    end
  end

  assign rsp.valid = out_valid_q;
  assign rsp.data  = out_data_q;

  bvrq_ctrl #(
    .AW (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .req_i       (req.data),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  bvrq_mem #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule
